FILE: hdl/ycc_pkg.sv
// ============================================================================
// ycc_pkg: shared types and constants of the 4:2:2 to RGB stream core
// Holds the group phase, job and result types, register indexes, channel
// codes and the fixed-point color coefficients.
// ============================================================================
package ycc_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 13'd160;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 13'd120;
    localparam logic [CFG_DATA_W-1:0] DIM_MIN_W    = 13'd2;
    localparam logic [CFG_DATA_W-1:0] DIM_MIN_H    = 13'd1;
    localparam logic [CFG_DATA_W-1:0] DIM_MAX      = 13'd4096;

    localparam int COL_W = 11;
    localparam int ROW_W = 12;

    // Channel codes.
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // Fixed-point arithmetic: every product and sum fits 27 signed bits.
    localparam int SUM_W = 27;
    localparam logic signed [SUM_W-1:0] K_Y      = 27'sd76310;
    localparam logic signed [SUM_W-1:0] K_RV     = 27'sd104635;
    localparam logic signed [SUM_W-1:0] K_GU     = -27'sd25690;
    localparam logic signed [SUM_W-1:0] K_GV     = -27'sd53294;
    localparam logic signed [SUM_W-1:0] K_BU     = 27'sd132278;
    localparam logic signed [SUM_W-1:0] Y_OFFSET = 27'sd16;
    localparam logic signed [SUM_W-1:0] C_OFFSET = 27'sd128;
    localparam logic signed [SUM_W-1:0] SAT_HIGH = 27'sh0FFFFFF;
    localparam logic signed [SUM_W-1:0] SAT_LOW  = 27'sh000FFFF;

    typedef enum logic [1:0] {
        PH_U,
        PH_Y0,
        PH_V,
        PH_Y1
    } t_phase;

    // One pixel to convert.
    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] u;
        logic [7:0] v;
        logic       frame_end;
    } t_job;

    // One output channel byte.
    typedef struct packed {
        logic [7:0] value;
        logic [1:0] channel;
        logic       run_last;
        logic       frame_end;
    } t_result;

endpackage

FILE: hdl/ycc_fifo.sv
// ============================================================================
// ycc_fifo: small register queue
// Flip-flop storage with push/full and pop/empty; the head entry is shown
// directly on the read data.
// ============================================================================
module ycc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: hdl/ycc_front.sv
// ============================================================================
// ycc_front: byte intake and group tracking
// Holds the frame registers, follows the U/Y0/V/Y1 phase, keeps the column
// and row counters and issues one conversion job per pixel.
// ============================================================================
module ycc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [ycc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ycc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_push,
    input  logic [7:0]                     i_byte,
    output logic                           o_full,
    output logic                           o_job_push,
    output ycc_pkg::t_job                  o_job,
    input  logic                           i_job_full
);

    logic [ycc_pkg::CFG_DATA_W-1:0] r_width, r_height;
    ycc_pkg::t_phase                r_phase, n_phase;
    logic [7:0]                     r_u, r_y0, r_v;
    logic [ycc_pkg::COL_W-1:0]      r_col, n_col;
    logic [ycc_pkg::ROW_W-1:0]      r_row, n_row;

    logic                           accept;
    logic [ycc_pkg::CFG_DATA_W-1:0] width_lim, height_lim;
    logic [ycc_pkg::COL_W:0]        groups_per_row, col_inc;
    logic [ycc_pkg::ROW_W:0]        row_inc;
    logic                           row_wrap, frame_wrap;

    assign o_full = i_job_full;
    assign accept = i_push && !i_job_full;

    // Out-of-range sizes are pulled into the supported range.
    always_comb begin
        width_lim = r_width;
        if (r_width < ycc_pkg::DIM_MIN_W) begin
            width_lim = ycc_pkg::DIM_MIN_W;
        end else if (r_width > ycc_pkg::DIM_MAX) begin
            width_lim = ycc_pkg::DIM_MAX;
        end
        height_lim = r_height;
        if (r_height < ycc_pkg::DIM_MIN_H) begin
            height_lim = ycc_pkg::DIM_MIN_H;
        end else if (r_height > ycc_pkg::DIM_MAX) begin
            height_lim = ycc_pkg::DIM_MAX;
        end
    end

    assign groups_per_row = width_lim[ycc_pkg::CFG_DATA_W-1:1];
    assign col_inc        = {1'b0, r_col} + 1'b1;
    assign row_inc        = {1'b0, r_row} + 1'b1;
    assign row_wrap       = (col_inc >= groups_per_row);
    assign frame_wrap     = row_wrap && (row_inc >= height_lim);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            case (r_phase)
                ycc_pkg::PH_U:  n_phase = ycc_pkg::PH_Y0;
                ycc_pkg::PH_Y0: n_phase = ycc_pkg::PH_V;
                ycc_pkg::PH_V:  n_phase = ycc_pkg::PH_Y1;
                ycc_pkg::PH_Y1: n_phase = ycc_pkg::PH_U;
                default:        n_phase = ycc_pkg::PH_U;
            endcase
        end
    end

    // Job issue and counter updates.
    always_comb begin
        o_job_push      = 1'b0;
        o_job.luma      = r_y0;
        o_job.u         = r_u;
        o_job.v         = i_byte;
        o_job.frame_end = 1'b0;
        n_col           = r_col;
        n_row           = r_row;
        case (r_phase)
            ycc_pkg::PH_V: begin
                o_job_push = accept;
            end
            ycc_pkg::PH_Y1: begin
                o_job_push      = accept;
                o_job.luma      = i_byte;
                o_job.v         = r_v;
                o_job.frame_end = frame_wrap;
                if (accept) begin
                    n_col = row_wrap ? '0 : col_inc[ycc_pkg::COL_W-1:0];
                    if (row_wrap) begin
                        n_row = frame_wrap ? '0 : row_inc[ycc_pkg::ROW_W-1:0];
                    end
                end
            end
            default: begin
                o_job_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ycc_pkg::WIDTH_RESET;
            r_height <= ycc_pkg::HEIGHT_RESET;
            r_phase  <= ycc_pkg::PH_U;
            r_u      <= '0;
            r_y0     <= '0;
            r_v      <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    ycc_pkg::REG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                    ycc_pkg::REG_FRAME_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            r_phase <= n_phase;
            r_col   <= n_col;
            r_row   <= n_row;
            if (accept) begin
                case (r_phase)
                    ycc_pkg::PH_U:  r_u  <= i_byte;
                    ycc_pkg::PH_Y0: r_y0 <= i_byte;
                    ycc_pkg::PH_V:  r_v  <= i_byte;
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: hdl/ycc_back.sv
// ============================================================================
// ycc_back: color conversion engine
// Turns one pixel job into its luma and chroma products, then sums, clamps and
// emits red, green and blue, one channel per cycle while i_res_full is low.
// ============================================================================
module ycc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_empty,
    input  ycc_pkg::t_job     i_job,
    output logic              o_job_pop,
    output logic              o_res_push,
    output ycc_pkg::t_result  o_res,
    input  logic              i_res_full
);

    localparam int SW = ycc_pkg::SUM_W;

    logic                 r_m_valid;
    logic                 r_m_last;
    logic signed [SW-1:0] r_y_term, r_r_term, r_g_term, r_b_term;
    logic [1:0]           r_ch;

    logic                 emit, stage_free;
    logic signed [SW-1:0] y_off, u_off, v_off;
    logic signed [SW-1:0] y_prod, rv_prod, gu_prod, gv_prod, bu_prod;
    logic signed [SW-1:0] chroma, sum;
    logic [7:0]           value;

    assign emit       = r_m_valid && !i_res_full;
    assign stage_free = !r_m_valid || (emit && (r_ch == ycc_pkg::CH_BLUE));
    assign o_job_pop  = stage_free && !i_job_empty;

    // Product stage.
    assign y_off   = $signed({{(SW-8){1'b0}}, i_job.luma}) - ycc_pkg::Y_OFFSET;
    assign u_off   = $signed({{(SW-8){1'b0}}, i_job.u}) - ycc_pkg::C_OFFSET;
    assign v_off   = $signed({{(SW-8){1'b0}}, i_job.v}) - ycc_pkg::C_OFFSET;
    assign y_prod  = y_off * ycc_pkg::K_Y;
    assign rv_prod = v_off * ycc_pkg::K_RV;
    assign gu_prod = u_off * ycc_pkg::K_GU;
    assign gv_prod = v_off * ycc_pkg::K_GV;
    assign bu_prod = u_off * ycc_pkg::K_BU;

    // Sum and clamp stage.
    always_comb begin
        case (r_ch)
            ycc_pkg::CH_RED:   chroma = r_r_term;
            ycc_pkg::CH_GREEN: chroma = r_g_term;
            default:           chroma = r_b_term;
        endcase
        sum = r_y_term + chroma;
        if (sum > ycc_pkg::SAT_HIGH) begin
            value = 8'hFF;
        end else if (sum <= ycc_pkg::SAT_LOW) begin
            value = 8'h00;
        end else begin
            value = sum[23:16];
        end
    end

    assign o_res_push      = emit;
    assign o_res.value     = value;
    assign o_res.channel   = r_ch;
    assign o_res.run_last  = (r_ch == ycc_pkg::CH_BLUE);
    assign o_res.frame_end = r_m_last && (r_ch == ycc_pkg::CH_BLUE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_ch      <= ycc_pkg::CH_RED;
        end else begin
            if (stage_free) begin
                r_m_valid <= !i_job_empty;
            end
            if (emit) begin
                r_ch <= (r_ch == ycc_pkg::CH_BLUE) ? ycc_pkg::CH_RED : r_ch + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_m_last <= i_job.frame_end;
            r_y_term <= y_prod;
            r_r_term <= rv_prod;
            r_g_term <= gu_prod + gv_prod;
            r_b_term <= bu_prod;
        end
    end

endmodule

FILE: hdl/ycc422_to_rgb_stream_core.sv
// ============================================================================
// ycc422_to_rgb_stream_core: packed 4:2:2 YCbCr byte stream to RGB888 bytes
// A V or Y1 transfer writes a job into the job queue; the back pops it into its
// product registers and writes red, green and blue in turn into the output
// queue. Throughput: one output byte per cycle from the single sum-and-clamp
// stage while the output queue has room; a 4-byte group gives 6 output bytes.
// Reset (synchronous, active low) empties both queues, clears the phase and
// counters, and loads the frame size registers with 160 by 120.
// ============================================================================
module ycc422_to_rgb_stream_core #(
    parameter int JOB_DEPTH = 4,
    parameter int OUT_DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration writes, for the user to make only while the core is idle; the core does not enforce it.
    input  logic                           i_cfg_wr_en,
    input  logic [ycc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ycc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Byte input, queue style.
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_byte_in,
    // Color byte output, queue style.
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     o_out_value,
    output logic [1:0]                     o_out_channel,
    output logic                           o_run_last,
    output logic                           o_frame_end
);

    // The front tracks the group phase and counters; every V and Y1 transfer
    // becomes one pixel job. The job queue lets the front keep taking bytes
    // while the back is still working on earlier pixels.
    logic             job_push, job_full, job_pop, job_empty;
    ycc_pkg::t_job    job_in, job_head;

    // The back writes one channel byte per cycle, while there is room, into a short
    // output queue, so a briefly stalled consumer does not at once halt the back.
    logic             res_push, res_full;
    ycc_pkg::t_result res_in, res_head;

    ycc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_byte      (i_byte_in),
        .o_full      (full),
        .o_job_push  (job_push),
        .o_job       (job_in),
        .i_job_full  (job_full)
    );

    ycc_fifo #(
        .WIDTH ($bits(ycc_pkg::t_job)),
        .DEPTH (JOB_DEPTH)
    ) u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_head),
        .o_empty (job_empty)
    );

    ycc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_head),
        .o_job_pop   (job_pop),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    ycc_fifo #(
        .WIDTH ($bits(ycc_pkg::t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_empty (empty)
    );

    // The oldest result sits on the ports while empty is low.
    assign o_out_value   = res_head.value;
    assign o_out_channel = res_head.channel;
    assign o_run_last    = res_head.run_last;
    assign o_frame_end   = res_head.frame_end;

endmodule
